### src/assert_macros.svh
// Assertion macros shared by the pressure trend history modules.
// Depends on nothing; simulation builds get the checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check that is switched off while reset is high.
`define PTH_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define PTH_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PTH_ASSERT(name, clk, rst, prop, msg)

`define PTH_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

### src/pth_pkg.sv
// Widths, decimation constants, stage words and the reciprocal mean function
// of the pressure trend history block. Depends on nothing.
package pth_pkg;

  // Field widths.
  localparam int PRESS_W  = 17;
  localparam int CHANGE_W = 18;
  localparam int SRC_W    = 2;
  localparam int HELD_W   = 5;
  localparam int COUNT_W  = 6;
  localparam int SUM_W    = 23;

  // Decimation ratios and history size.
  localparam int SAMPLES_PER_MINUTE = 60;
  localparam int MINUTES_PER_HOUR   = 60;
  localparam int HOUR_SLOTS         = 24;

  // The ring holds at most one entry fewer than it has slots.
  localparam int HIST_AW  = $clog2(HOUR_SLOTS);
  localparam int FILL_W   = $clog2(HOUR_SLOTS);
  localparam int FILL_MAX = HOUR_SLOTS - 1;

  // Reciprocal constants: a sum below 2**SUM_W divided by a ratio below
  // 2**COUNT_W is exact with a shift of SUM_W + COUNT_W and a rounded-up
  // reciprocal.
  localparam int DIV_SHIFT = SUM_W + COUNT_W;
  localparam int RECIP_W   = DIV_SHIFT;
  localparam logic [RECIP_W-1:0] MINUTE_RECIP = RECIP_W'(
    ((64'd1 << DIV_SHIFT) + SAMPLES_PER_MINUTE - 1) / SAMPLES_PER_MINUTE);
  localparam logic [RECIP_W-1:0] HOUR_RECIP = RECIP_W'(
    ((64'd1 << DIV_SHIFT) + MINUTES_PER_HOUR - 1) / MINUTES_PER_HOUR);

  // Where the trend reference came from.
  typedef enum logic [SRC_W-1:0] {
    SRC_HOUR   = 2'd0,
    SRC_MINUTE = 2'd1,
    SRC_SAMPLE = 2'd2
  } ref_src_t;

  // Word handed from the averaging stages to the history stage.
  typedef struct packed {
    logic [PRESS_W-1:0] sample;
    logic [PRESS_W-1:0] first_sample;
    logic [PRESS_W-1:0] first_minute;
    logic               minute_open;
    logic               hour_push;
    logic [PRESS_W-1:0] hour_avg;
  } avg_word_t;

  // Word handed from the history stage to the output formatting.
  typedef struct packed {
    logic [PRESS_W-1:0] sample;
    logic [PRESS_W-1:0] first_sample;
    logic [PRESS_W-1:0] first_minute;
    logic               minute_open;
    logic [FILL_W-1:0]  fill;
    logic [PRESS_W-1:0] oldest;
  } hist_word_t;

  // Truncated mean by multiplication with a reciprocal and a shift.
  function automatic logic [PRESS_W-1:0] scaled_mean(input logic [SUM_W-1:0] sum,
                                                      input logic [RECIP_W-1:0] recip);
    logic [SUM_W+RECIP_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, recip};
    return prod[DIV_SHIFT +: PRESS_W];
  endfunction

endpackage

### src/pth_ifs.sv
// Valid/ready channel interfaces for pressure samples and trend results.
// Depends on pth_pkg for the field widths.
interface pth_sample_if;
  logic                        valid;
  logic                        ready;
  logic [pth_pkg::PRESS_W-1:0] pressure_pa;

  modport source (output valid, output pressure_pa, input ready);
  modport sink (input valid, input pressure_pa, output ready);
endinterface

interface pth_result_if;
  logic                                valid;
  logic                                ready;
  logic [pth_pkg::PRESS_W-1:0]         reference_pa;
  logic signed [pth_pkg::CHANGE_W-1:0] change_pa;
  logic [pth_pkg::SRC_W-1:0]           reference_source;
  logic [pth_pkg::HELD_W-1:0]          hours_held;

  modport source (output valid, output reference_pa, output change_pa,
                  output reference_source, output hours_held, input ready);
  modport sink (input valid, input reference_pa, input change_pa,
                input reference_source, input hours_held, output ready);
endinterface

### src/pth_hist_ram.sv
// Hour history memory: one write port and one registered read port.
// Depends on pth_pkg for the depth and the word width.
module pth_hist_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [pth_pkg::HIST_AW-1:0] waddr,
  input  logic [pth_pkg::PRESS_W-1:0] wdata,
  input  logic                        re,
  input  logic [pth_pkg::HIST_AW-1:0] raddr,
  output logic [pth_pkg::PRESS_W-1:0] rdata
);

  logic [pth_pkg::PRESS_W-1:0] mem [pth_pkg::HOUR_SLOTS];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/pth_average.sv
// Four-stage averaging pipeline: sample accumulation, minute mean, minute
// accumulation and hour mean. Depends on pth_pkg and pth_ifs.
module pth_average (
  input  logic               clk,
  input  logic               rst,
  pth_sample_if.sink         sample_ch,
  output logic               hvalid,
  input  logic               hready,
  output pth_pkg::avg_word_t hword
);

  // Running state of the current minute and hour.
  logic [pth_pkg::SUM_W-1:0]   second_sum;
  logic [pth_pkg::COUNT_W-1:0] second_count;
  logic [pth_pkg::PRESS_W-1:0] first_second_sample;
  logic [pth_pkg::SUM_W-1:0]   minute_sum;
  logic [pth_pkg::COUNT_W-1:0] minute_count;
  logic [pth_pkg::PRESS_W-1:0] first_minute_average;

  // Stage valid bits and advance enables.
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  // Stage payloads.
  logic [pth_pkg::PRESS_W-1:0] s1_sample, s1_first;
  logic                        s1_end;
  logic [pth_pkg::SUM_W-1:0]   s1_sum;
  logic [pth_pkg::PRESS_W-1:0] s2_sample, s2_first, s2_avg;
  logic                        s2_end;
  logic [pth_pkg::PRESS_W-1:0] s3_sample, s3_first, s3_first_minute;
  logic                        s3_open, s3_push;
  logic [pth_pkg::SUM_W-1:0]   s3_sum;

  // Combinational results of the two accumulation stages.
  logic                        take;
  logic [pth_pkg::PRESS_W-1:0] first_now;
  logic [pth_pkg::SUM_W-1:0]   sum_new;
  logic [pth_pkg::COUNT_W-1:0] count_new;
  logic                        minute_end;
  logic                        absorb;
  logic [pth_pkg::PRESS_W-1:0] first_minute_now;
  logic [pth_pkg::SUM_W-1:0]   msum_new;
  logic [pth_pkg::COUNT_W-1:0] mcount_new;
  logic [pth_pkg::COUNT_W-1:0] mcount_after;
  logic                        hour_end;

  // A stage loads when it is empty or its word moves on.
  assign en4 = !v4 || hready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign sample_ch.ready = en1;
  assign take = sample_ch.valid && en1;

  // Sample accumulation for the current minute.
  always_comb begin
    first_now  = (second_count == '0) ? sample_ch.pressure_pa : first_second_sample;
    sum_new    = second_sum + pth_pkg::SUM_W'(sample_ch.pressure_pa);
    count_new  = second_count + pth_pkg::COUNT_W'(1);
    minute_end = (count_new == pth_pkg::COUNT_W'(pth_pkg::SAMPLES_PER_MINUTE));
  end

  // Minute average accumulation for the current hour.
  always_comb begin
    absorb           = v2 && en3;
    first_minute_now = first_minute_average;
    msum_new         = minute_sum;
    mcount_new       = minute_count;
    hour_end         = 1'b0;
    if (s2_end) begin
      if (minute_count == '0) begin
        first_minute_now = s2_avg;
      end
      msum_new   = minute_sum + pth_pkg::SUM_W'(s2_avg);
      mcount_new = minute_count + pth_pkg::COUNT_W'(1);
      hour_end   = (mcount_new == pth_pkg::COUNT_W'(pth_pkg::MINUTES_PER_HOUR));
    end
    mcount_after = hour_end ? '0 : mcount_new;
  end

  // Control state and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      second_sum           <= '0;
      second_count         <= '0;
      first_second_sample  <= '0;
      minute_sum           <= '0;
      minute_count         <= '0;
      first_minute_average <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (take) begin
        first_second_sample <= first_now;
        second_sum          <= minute_end ? '0 : sum_new;
        second_count        <= minute_end ? '0 : count_new;
      end
      if (absorb) begin
        first_minute_average <= first_minute_now;
        minute_sum           <= hour_end ? '0 : msum_new;
        minute_count         <= mcount_after;
      end
      if (en1) v1 <= sample_ch.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage payloads; the multiplications each end in a register.
  always_ff @(posedge clk) begin
    if (take) begin
      s1_sample <= sample_ch.pressure_pa;
      s1_first  <= first_now;
      s1_end    <= minute_end;
      s1_sum    <= sum_new;
    end
    if (v1 && en2) begin
      s2_sample <= s1_sample;
      s2_first  <= s1_first;
      s2_end    <= s1_end;
      s2_avg    <= pth_pkg::scaled_mean(s1_sum, pth_pkg::MINUTE_RECIP);
    end
    if (absorb) begin
      s3_sample       <= s2_sample;
      s3_first        <= s2_first;
      s3_first_minute <= first_minute_now;
      s3_open         <= (mcount_after != '0);
      s3_push         <= hour_end;
      s3_sum          <= msum_new;
    end
    if (v3 && en4) begin
      hword.sample       <= s3_sample;
      hword.first_sample <= s3_first;
      hword.first_minute <= s3_first_minute;
      hword.minute_open  <= s3_open;
      hword.hour_push    <= s3_push;
      hword.hour_avg     <= pth_pkg::scaled_mean(s3_sum, pth_pkg::HOUR_RECIP);
    end
  end

  assign hvalid = v4;

endmodule

### src/pth_history.sv
// History stage: pushes hour averages into the ring memory and reads the
// oldest entry, forwarding a same-cycle write. Depends on pth_pkg and pth_hist_ram.
`include "assert_macros.svh"

module pth_history (
  input  logic                clk,
  input  logic                rst,
  input  logic                hvalid,
  output logic                hready,
  input  pth_pkg::avg_word_t  hword,
  output logic                ovalid,
  input  logic                oready,
  output pth_pkg::hist_word_t oword
);

  // Ring pointers.
  logic [pth_pkg::HIST_AW-1:0] ptr, ptr_next, ptr_step;
  logic [pth_pkg::FILL_W-1:0]  fill, fill_next;
  logic                        full;

  // Stage control.
  logic v5, en5, load, push;

  // Write slot and forwarding.
  logic [pth_pkg::HIST_AW:0]   slot_sum;
  logic [pth_pkg::HIST_AW-1:0] wslot;
  logic                        fwd;
  logic [pth_pkg::PRESS_W-1:0] rdata;

  // Output stage payload.
  logic [pth_pkg::PRESS_W-1:0] o_sample, o_first, o_first_minute, o_fwd_data;
  logic                        o_open, o_fwd;
  logic [pth_pkg::FILL_W-1:0]  o_fill;

  assign en5    = !v5 || oready;
  assign hready = en5;
  assign load   = hvalid && en5;
  assign push   = load && hword.hour_push;

  // Next ring position: newest goes after the held entries, oldest drops when full.
  always_comb begin
    full     = (fill == pth_pkg::FILL_W'(pth_pkg::FILL_MAX));
    slot_sum = (pth_pkg::HIST_AW + 1)'(ptr) + (pth_pkg::HIST_AW + 1)'(fill);
    if (slot_sum >= (pth_pkg::HIST_AW + 1)'(pth_pkg::HOUR_SLOTS)) begin
      wslot = pth_pkg::HIST_AW'(slot_sum - (pth_pkg::HIST_AW + 1)'(pth_pkg::HOUR_SLOTS));
    end else begin
      wslot = pth_pkg::HIST_AW'(slot_sum);
    end
    ptr_step  = (ptr == pth_pkg::HIST_AW'(pth_pkg::HOUR_SLOTS - 1)) ?
                '0 : ptr + pth_pkg::HIST_AW'(1);
    ptr_next  = (push && full) ? ptr_step : ptr;
    fill_next = (push && !full) ? fill + pth_pkg::FILL_W'(1) : fill;
    fwd       = push && (wslot == ptr_next);
  end

  pth_hist_ram u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wslot),
    .wdata (hword.hour_avg),
    .re    (load),
    .raddr (ptr_next),
    .rdata (rdata)
  );

  // Ring state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      fill <= '0;
      v5   <= 1'b0;
    end else begin
      if (load) begin
        ptr  <= ptr_next;
        fill <= fill_next;
      end
      if (en5) v5 <= hvalid;
    end
  end

  // Output stage payload, loaded with the memory read.
  always_ff @(posedge clk) begin
    if (load) begin
      o_sample       <= hword.sample;
      o_first        <= hword.first_sample;
      o_first_minute <= hword.first_minute;
      o_open         <= hword.minute_open;
      o_fill         <= fill_next;
      o_fwd          <= fwd;
      o_fwd_data     <= hword.hour_avg;
    end
  end

  assign ovalid             = v5;
  assign oword.sample       = o_sample;
  assign oword.first_sample = o_first;
  assign oword.first_minute = o_first_minute;
  assign oword.minute_open  = o_open;
  assign oword.fill         = o_fill;
  assign oword.oldest       = o_fwd ? o_fwd_data : rdata;

  `PTH_ASSERT(a_fill_bound, clk, rst, fill <= pth_pkg::FILL_W'(pth_pkg::FILL_MAX), "hour fill beyond ring capacity")
  `PTH_ASSERT(a_ptr_range, clk, rst, ptr <= pth_pkg::HIST_AW'(pth_pkg::HOUR_SLOTS - 1), "oldest pointer outside ring")
  `PTH_ASSERT(a_full_push_rotates, clk, rst, (push && full) |=> (fill == $past(fill)) && (ptr != $past(ptr)), "push into full ring did not drop oldest")
  `PTH_ASSERT(a_idle_keeps_ring, clk, rst, !push |=> $stable(fill) && $stable(ptr), "ring moved without a push")
  `PTH_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !v5 && (fill == '0), "reset left a word or history count")

endmodule

### src/pressure_trend_history.sv
// Pressure trend history, top level: five register stages from pth_average and pth_history.
// Each stage holds one word and moves on when the next frees.
// Throughput: one sample per cycle while the result channel is ready.
// Reset clears sums, counts, ring pointer, fill and valid bits; the history memory
// is not cleared, an entry's value is used only once written. Depends on pth_pkg and pth_ifs.
module pressure_trend_history (
  input  logic         clk,
  input  logic         rst,
  pth_sample_if.sink   sample_ch,
  pth_result_if.source result_ch
);

  pth_pkg::avg_word_t  hword;
  pth_pkg::hist_word_t oword;
  logic                hvalid, hready;
  pth_pkg::ref_src_t   src;
  logic [pth_pkg::PRESS_W-1:0] reference;

  pth_average u_average (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .hvalid    (hvalid),
    .hready    (hready),
    .hword     (hword)
  );

  pth_history u_history (
    .clk    (clk),
    .rst    (rst),
    .hvalid (hvalid),
    .hready (hready),
    .hword  (hword),
    .ovalid (result_ch.valid),
    .oready (result_ch.ready),
    .oword  (oword)
  );

  // Reference: oldest hour average, else first minute average, else first sample.
  always_comb begin
    priority if (oword.fill != '0) begin
      reference = oword.oldest;
      src       = pth_pkg::SRC_HOUR;
    end else if (oword.minute_open) begin
      reference = oword.first_minute;
      src       = pth_pkg::SRC_MINUTE;
    end else begin
      reference = oword.first_sample;
      src       = pth_pkg::SRC_SAMPLE;
    end
  end

  assign result_ch.reference_pa     = reference;
  assign result_ch.change_pa        = $signed(pth_pkg::CHANGE_W'(oword.sample) -
                                              pth_pkg::CHANGE_W'(reference));
  assign result_ch.reference_source = src;
  assign result_ch.hours_held       = pth_pkg::HELD_W'(oword.fill);

endmodule
